/* rtl/core/assert_macros.svh */
// assertion macros used by the radix string parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/core/rsti_pkg.sv */
// constants, register indexes and helpers for the radix string parser
package rsti_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LEN_W       = 6;
    localparam int SYM_W       = 8;
    localparam int SYM_PER_REG = CFG_DATA_W / SYM_W;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [SYM_W-1:0]     sym_t;
    typedef logic [LEN_W-1:0]     len_t;

    localparam cfg_index_t REG_SYMBOLS_0 = 3'd0;
    localparam cfg_index_t REG_LENGTH    = 3'd4;

    localparam sym_t CH_NUL   = 8'h00;
    localparam sym_t CH_TAB   = 8'h09;
    localparam sym_t CH_CR    = 8'h0D;
    localparam sym_t CH_SPACE = 8'h20;
    localparam sym_t CH_PLUS  = 8'h2B;
    localparam sym_t CH_MINUS = 8'h2D;

    function automatic logic is_space(input sym_t c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

/* rtl/core/radix_string_to_int.sv */
// radix string parser: byte stream in, signed integer per string out
`include "assert_macros.svh"

// Parses a byte stream, one character per request, into a signed
// VALUE_WIDTH-bit integer in a configurable radix. The digit alphabet is
// written to registers 0 to 3 (symbol k in byte k mod 8 of register k div 8)
// and the radix to register 4; configure only while no request is in flight.
// A request with s_tuser set starts a new string: leading whitespace is
// skipped, then any run of '+' and '-' (each '-' flips the sign), then
// digits are accumulated as acc * radix + digit, wrapping. The first other
// character gives one result with m_tuser set; with an invalid alphabet the
// first character gives 0 with m_tuser clear. Later characters up to the
// next s_tuser request give nothing. One character is taken every cycle
// while the input does not stall; a result passes from the input register
// through the parse step into the result register. Besides configuration
// writes, input stalls only while a result waits unaccepted with the input
// register full. s_tready is low in a cycle that carries a configuration write.
module radix_string_to_int #(
    parameter int MAX_BASE    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  rsti_pkg::cfg_index_t             cfg_index,
    input  logic [rsti_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // character[7:0]
    input  logic                             s_tuser,   // first
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata,   // value, zero padded
    output logic                             m_tuser    // base_ok
);
    import rsti_pkg::*;

    localparam int DIGIT_W = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
    localparam int DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } phase_t;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // configuration
    sym_t sym_reg [MAX_BASE];
    len_t len_reg;
    logic base_ok_reg;
    logic base_bad;

    // input register
    logic in_valid_reg;
    sym_t char_reg;
    logic first_reg;

    // parse state and result register
    phase_t phase_reg, phase_next, cur_phase;
    logic   neg_reg, neg_next, cur_neg;
    value_t acc_reg, acc_next, cur_acc;
    logic   out_valid_reg;
    value_t value_reg, value_next;
    logic   ok_reg, ok_next;
    logic   emit;

    logic                 advance;
    logic                 process;
    logic                 in_take;
    logic [MAX_BASE-1:0]  match;
    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
    value_t               mac_full;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_BASE; k++)
                sym_reg[k] <= CH_NUL;
            len_reg     <= '0;
            base_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int k = 0; k < MAX_BASE; k++)
                    if (cfg_index == REG_SYMBOLS_0 + CFG_IDX_W'(k / SYM_PER_REG))
                        sym_reg[k] <= cfg_data[(k % SYM_PER_REG)*SYM_W +: SYM_W];
                if (cfg_index == REG_LENGTH)
                    len_reg <= cfg_data[LEN_W-1:0];
            end
            base_ok_reg <= !base_bad;
        end
    end

    // alphabet check: length range, reserved bytes and duplicates
    always_comb
    begin
        base_bad = (len_reg < LEN_W'(2)) || (len_reg > LEN_W'(MAX_BASE));
        for (int i = 0; i < MAX_BASE; i++)
        begin
            if (LEN_W'(i) < len_reg)
            begin
                if (sym_reg[i] == CH_NUL || sym_reg[i] == CH_PLUS ||
                    sym_reg[i] == CH_MINUS || is_space(sym_reg[i]))
                    base_bad = 1'b1;
                for (int j = 0; j < i; j++)
                    if (sym_reg[j] == sym_reg[i])
                        base_bad = 1'b1;
            end
        end
    end

    // ---------------- handshake ----------------
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign in_take  = !in_valid_reg || advance;
    // a write lands in the same cycle, so hold off until the check is registered
    assign s_tready = in_take && !cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            char_reg     <= CH_NUL;
            first_reg    <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                char_reg  <= s_tdata;
                first_reg <= s_tuser;
            end
        end
    end

    // ---------------- digit lookup and mac ----------------
    always_comb
    begin
        for (int i = 0; i < MAX_BASE; i++)
            match[i] = (LEN_W'(i) < len_reg) && (sym_reg[i] == char_reg);
    end

    // symbols are distinct when the base is valid, so or-ing the indexes is exact
    always_comb
    begin
        digit = '0;
        for (int i = 0; i < MAX_BASE; i++)
            if (match[i])
                digit = digit | DIGIT_W'(i);
    end

    assign is_digit = |match;
    assign mac_full = cur_acc * VALUE_WIDTH'(len_reg) + VALUE_WIDTH'(digit);

    // ---------------- parse step ----------------
    always_comb
    begin
        cur_phase  = first_reg ? PH_SPACE : phase_reg;
        cur_neg    = first_reg ? 1'b0 : neg_reg;
        cur_acc    = first_reg ? '0 : acc_reg;
        phase_next = cur_phase;
        neg_next   = cur_neg;
        acc_next   = cur_acc;
        emit       = 1'b0;
        value_next = '0;
        ok_next    = 1'b0;
        if (cur_phase != PH_DONE)
        begin
            if (!base_ok_reg)
            begin
                phase_next = PH_DONE;
                emit       = 1'b1;
            end
            else if (cur_phase == PH_SPACE && is_space(char_reg))
            begin
                phase_next = PH_SPACE;
            end
            else if (cur_phase != PH_DIGIT &&
                     (char_reg == CH_PLUS || char_reg == CH_MINUS))
            begin
                neg_next   = cur_neg ^ (char_reg == CH_MINUS);
                phase_next = PH_SIGN;
            end
            else if (is_digit)
            begin
                acc_next   = mac_full;
                phase_next = PH_DIGIT;
            end
            else
            begin
                phase_next = PH_DONE;
                emit       = 1'b1;
                ok_next    = 1'b1;
                value_next = cur_neg ? (~cur_acc) + VALUE_WIDTH'(1) : cur_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
            if (advance)
            begin
                out_valid_reg <= process && emit;
                if (process && emit)
                begin
                    value_reg <= value_next;
                    ok_reg    <= ok_next;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(value_reg);
    assign m_tuser  = ok_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPL(a_invalid_gives_zero, m_tvalid && !m_tuser, m_tdata == '0)
    `ASSERT_IMPL(a_done_is_silent, process && !first_reg && phase_reg == PH_DONE, !emit)
    `ASSERT_NEXT(a_emit_ends_parse, process && emit, phase_reg == PH_DONE)
    `ASSERT_IMPL(a_empty_stage_ready, !in_valid_reg && !cfg_we, s_tready)

endmodule

/* tb/radix_string_to_int_test.sv */
// self-checking testbench for the radix string parser
module radix_string_to_int_test;
    import rsti_pkg::*;

    localparam int VALUE_W        = 32;
    localparam int MAX_RADIX      = 32;
    localparam int RESULT_LATENCY = 2;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 1250;

    typedef enum logic [1:0] {
        P_BLANKS,
        P_SIGNS,
        P_DIGITS,
        P_IDLE
    } parse_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               base_ok;
    } parse_result_t;

    logic                                  clk       = 1'b0;
    logic                                  rst_n     = 1'b0;
    logic                                  cfg_we    = 1'b0;
    cfg_index_t                            cfg_index = REG_SYMBOLS_0;
    logic [CFG_DATA_W-1:0]                 cfg_data  = '0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [7:0]                            s_tdata   = '0;
    logic                                  s_tuser   = 1'b0;
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [((VALUE_W+7)/8)*8-1:0]          m_tdata;
    logic                                  m_tuser;

    // alphabet and parse state as the block should hold them
    logic [255:0]  alpha_syms = '0;
    len_t          radix_q    = '0;
    parse_phase_t  phase_q    = P_IDLE;
    logic          neg_q      = 1'b0;
    logic [VALUE_W-1:0] acc_q = '0;

    parse_result_t pending_values[$];
    int unsigned   active_items   = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles    = 0;
    bit            gaps_on        = 1'b1;

    radix_string_to_int dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic logic is_blank(input sym_t c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic symbol_usable(input sym_t c);
        return c != CH_NUL && c != CH_PLUS && c != CH_MINUS && !is_blank(c);
    endfunction

    function automatic logic alphabet_ok();
        sym_t s;
        if (radix_q < 2 || radix_q > MAX_RADIX)
            return 1'b0;
        for (int k = 0; k < radix_q; k++)
        begin
            s = alpha_syms[8*k +: 8];
            if (!symbol_usable(s))
                return 1'b0;
            for (int j = 0; j < k; j++)
                if (alpha_syms[8*j +: 8] == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_value(input sym_t c);
        for (int k = 0; k < MAX_RADIX && k < radix_q; k++)
            if (alpha_syms[8*k +: 8] == c)
                return k;
        return -1;
    endfunction

    // advance the expected parse state by one character
    function automatic void parse_char(input sym_t c, input logic restart);
        int d;
        active_items++;
        if (restart)
        begin
            phase_q = P_BLANKS;
            neg_q   = 1'b0;
            acc_q   = '0;
        end
        if (phase_q == P_IDLE)
            return;
        if (!alphabet_ok())
        begin
            phase_q = P_IDLE;
            pending_values.push_back('{value: '0, base_ok: 1'b0});
            return;
        end
        if (phase_q == P_BLANKS && is_blank(c))
            return;
        if (phase_q != P_DIGITS && (c == CH_PLUS || c == CH_MINUS))
        begin
            if (c == CH_MINUS)
                neg_q = ~neg_q;
            phase_q = P_SIGNS;
            return;
        end
        d = digit_value(c);
        if (d >= 0)
        begin
            acc_q   = acc_q * VALUE_W'(radix_q) + VALUE_W'(d);
            phase_q = P_DIGITS;
            return;
        end
        phase_q = P_IDLE;
        pending_values.push_back('{value: neg_q ? -acc_q : acc_q, base_ok: 1'b1});
    endfunction

    function automatic logic [255:0] text_alphabet(input string txt);
        logic [255:0] syms;
        syms = '0;
        for (int k = 0; k < txt.len() && k < MAX_RADIX; k++)
            syms[8*k +: 8] = txt[k];
        return syms;
    endfunction

    function automatic logic [255:0] random_alphabet(input int count);
        logic [255:0] syms;
        logic [255:0] taken;
        sym_t         c;
        taken = '0;
        for (int r = 0; r < 8; r++)
            syms[32*r +: 32] = $urandom;
        for (int k = 0; k < count; k++)
        begin
            do
                c = sym_t'($urandom_range(255));
            while (taken[c] || !symbol_usable(c));
            taken[c] = 1'b1;
            syms[8*k +: 8] = c;
        end
        return syms;
    endfunction

    // one character request; valid stays high afterwards unless a gap follows
    task automatic push_char(input sym_t c, input logic restart);
        while (gaps_on && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_char(c, restart);
    endtask

    task automatic send_text(input string txt, input logic restart);
        for (int k = 0; k < txt.len(); k++)
            push_char(sym_t'(txt[k]), restart && k == 0);
    endtask

    // wait until every result is in and the pipeline has emptied
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2)
            @(posedge clk);
    endtask

    task automatic set_alphabet(input logic [255:0] syms, input len_t count);
        settle();
        for (int r = 0; r < 4; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_SYMBOLS_0 + cfg_index_t'(r);
            cfg_data  <= syms[64*r +: 64];
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_LENGTH;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_we     <= 1'b0;
        alpha_syms  = syms;
        radix_q     = count;
    endtask

    task automatic test_reset_idle();
        // nothing may come out before a character marked first
        push_char("A", 1'b0);
        push_char(CH_NUL, 1'b0);
        push_char("7", 1'b1);
    endtask

    task automatic test_bad_alphabets();
        logic [255:0] dec;
        logic [255:0] wide;
        logic [255:0] bad;
        dec  = text_alphabet("0123456789");
        wide = random_alphabet(MAX_RADIX);
        set_alphabet(dec, 1);
        send_text("1", 1'b1);
        set_alphabet(wide, 33);
        send_text("1", 1'b1);
        set_alphabet(wide, 63);
        send_text("1", 1'b1);
        set_alphabet(text_alphabet("0120"), 4);
        send_text("1", 1'b1);
        set_alphabet(text_alphabet("0+1"), 3);
        send_text("1", 1'b1);
        set_alphabet(text_alphabet("01-"), 3);
        send_text("1", 1'b1);
        set_alphabet(text_alphabet("0 1"), 3);
        send_text("1", 1'b1);
        bad = dec;
        bad[8*3 +: 8] = CH_TAB;
        set_alphabet(bad, 10);
        send_text("1", 1'b1);
        bad[8*3 +: 8] = CH_CR;
        set_alphabet(bad, 10);
        send_text("1", 1'b1);
        // eleventh symbol is a zero byte
        set_alphabet(dec, 11);
        send_text("1", 1'b1);
    endtask

    task automatic test_decimal_signs();
        set_alphabet(text_alphabet("0123456789"), 10);
        push_char(CH_SPACE, 1'b1);
        push_char(CH_TAB, 1'b0);
        push_char(CH_CR, 1'b0);
        send_text("-+-42", 1'b0);
        push_char(CH_NUL, 1'b0);
        push_char("7", 1'b0);
        // blank after a sign ends the parse
        send_text("-+ 5", 1'b1);
        send_text("7-3", 1'b1);
        send_text("x", 1'b1);
    endtask

    task automatic test_wraparound();
        logic [255:0] ext;
        for (int k = 0; k < MAX_RADIX; k++)
            ext[8*k +: 8] = 8'hE0 + sym_t'(k);
        ext[7:0] = 8'h01;
        set_alphabet(ext, MAX_RADIX);
        // seven top digits wrap to all ones
        push_char(8'hFF, 1'b1);
        repeat (6)
            push_char(8'hFF, 1'b0);
        push_char(CH_NUL, 1'b0);
        // minus two times 32^6, the most negative value
        push_char(CH_MINUS, 1'b1);
        push_char(8'hE2, 1'b0);
        repeat (6)
            push_char(8'h01, 1'b0);
        push_char(CH_SPACE, 1'b0);
    endtask

    task automatic test_reconfigure_midway();
        set_alphabet(text_alphabet("0123456789"), 10);
        send_text("12", 1'b1);
        set_alphabet(text_alphabet("0123456789ABCDEF"), 16);
        send_text("F.", 1'b0);
        send_text("3", 1'b1);
        set_alphabet(text_alphabet("0123456789"), 1);
        send_text("4", 1'b0);
    endtask

    task automatic send_random_string();
        logic lead;
        sym_t c;
        int   k;
        lead = 1'b1;
        if ($urandom_range(99) < 20)
        begin
            // noise, sometimes without a restart
            lead = 1'($urandom_range(1));
            repeat ($urandom_range(1, 8))
            begin
                push_char(sym_t'($urandom_range(255)), lead);
                lead = 1'b0;
            end
            return;
        end
        repeat ($urandom_range(3))
        begin
            c = ($urandom_range(4) == 0) ? CH_SPACE : CH_TAB + sym_t'($urandom_range(4));
            push_char(c, lead);
            lead = 1'b0;
        end
        repeat ($urandom_range(3))
        begin
            push_char($urandom_range(1) ? CH_MINUS : CH_PLUS, lead);
            lead = 1'b0;
        end
        if (radix_q != 0)
            repeat ($urandom_range(10))
            begin
                k = $urandom_range((radix_q > MAX_RADIX ? MAX_RADIX : radix_q) - 1);
                push_char(alpha_syms[8*k +: 8], lead);
                lead = 1'b0;
            end
        if ($urandom_range(3) == 0)
            c = CH_NUL;
        else
            do
                c = sym_t'($urandom_range(255));
            while (digit_value(c) >= 0);
        push_char(c, lead);
        // trailing characters are ignored
        repeat ($urandom_range(2))
            push_char(sym_t'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_random_strings();
        int unsigned goal;
        int          round;
        int          pick;
        len_t        count;
        goal  = RANDOM_ITEMS;
        round = 0;
        while (active_items < goal)
        begin
            gaps_on = (round % 8 != 4);
            pick    = $urandom_range(9);
            if (pick < 7)
            begin
                count = (pick == 0) ? len_t'(2) : (pick == 1) ? len_t'(MAX_RADIX) :
                        len_t'($urandom_range(2, MAX_RADIX));
                set_alphabet(random_alphabet(int'(count)), count);
            end
            else
                set_alphabet(random_alphabet(0), len_t'($urandom_range(63)));
            repeat (12)
                send_random_string();
            round++;
        end
        gaps_on = 1'b1;
    endtask

    // result side: random back-pressure and comparison
    always @(posedge clk)
    begin
        parse_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_values.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unpredicted result: value %h base_ok %b",
                                 m_tdata[VALUE_W-1:0], m_tuser);
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.value || m_tuser !== want.base_ok)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected value %h base_ok %b, got value %h base_ok %b",
                                     want.value, want.base_ok, m_tdata[VALUE_W-1:0], m_tuser);
                    end
                end
            end
            m_tready <= !(gaps_on && $urandom_range(99) < 30);
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[radix_string_to_int] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_idle();
        test_bad_alphabets();
        test_decimal_signs();
        test_wraparound();
        test_reconfigure_midway();
        test_random_strings();
        settle();
        if (mismatch_count == 0 && pending_values.size() == 0)
            $display("[radix_string_to_int] OK");
        else
            $display("[radix_string_to_int] ERROR");
        $finish;
    end

endmodule
